[hw/rtl/cmr_pkg.sv]
`timescale 1ns / 1ps
package cmr_pkg;
    localparam int MaxVertices = 256;
    localparam int MaxEdges    = 1024;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int DW = EW + 1;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_RUN    = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_DISJOINT = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ORDER    = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] vertex;
        logic [7:0] neighbor;
        logic [8:0] vertex_count;
        logic [7:0] root_vertex;
        logic       auto_start;
    } t_in;

    typedef struct packed {
        logic [7:0] remap_index;
        logic       index_valid;
        logic [2:0] status;
    } t_out;
endpackage

[hw/rtl/cmr_if.sv]
`timescale 1ns / 1ps
interface cmr_in_if;
    logic         valid;
    logic         ready;
    cmr_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmr_out_if;
    logic          valid;
    logic          ready;
    cmr_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cuthill_mckee_reorder.sv]
`timescale 1ns / 1ps
// Cuthill-McKee reordering engine.
// Input channel i_cmd (cmr_in_if sink): one command item per handshake:
//   append edge, run ordering, read new index, clear graph.
// Output channel o_res (cmr_out_if source): exactly one result item per
//   command, holding the remapped index, index_valid and the run status.
// The block is not ready while an item is in work or while a result waits
//   to be taken, so items are handled one at a time.
// Append passes through S_APP and read through S_READ and S_READ2 before
//   the result is offered in S_OUT. Clear: a sweep over all MaxVertices
//   entries, then the result.
// A run walks the graph with one sequencer: it clears marks over the
//   whole store, searches the automatic root as the lowest-degree vertex,
//   then per queued vertex reads its neighbors, marks each newly found one
//   and insertion-sorts it by degree, one shift per pass, before copying
//   the sorted neighbors into the queue.
// After reset a sweep over all MaxVertices entries zeroes degrees and marks,
//   during which no item is accepted.
// If the receiver stalls, the result is held and no new item is taken.
module cuthill_mckee_reorder (
    input logic i_clk,
    input logic i_rst_n,
    cmr_in_if.sink    i_cmd,
    cmr_out_if.source o_res
);
    localparam int VW = cmr_pkg::VW;
    localparam int EW = cmr_pkg::EW;
    localparam int DW = cmr_pkg::DW;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_APP, S_READ, S_READ2,
        S_RCLR, S_ROOT, S_ROOTCMP, S_POP, S_POP2, S_POP3,
        S_NB, S_NB2, S_NB3, S_SORT, S_SORT2, S_COPY, S_COPY2, S_DONE, S_OUT
    } t_state;

    // memories
    logic [EW-1:0]  row_start   [cmr_pkg::MaxVertices];
    logic [DW-1:0]  degree_mem  [cmr_pkg::MaxVertices];
    logic [VW-1:0]  nbr_mem     [cmr_pkg::MaxEdges];
    logic [VW-1:0]  queue_mem   [cmr_pkg::MaxVertices];
    logic [VW-1:0]  pos_mem     [cmr_pkg::MaxVertices];
    logic [DW+VW-1:0] sort_mem  [cmr_pkg::MaxVertices];
    logic           visit_mem   [cmr_pkg::MaxVertices];

    t_state         r_state;
    cmr_pkg::t_in   r_in;
    cmr_pkg::t_out  r_out;
    logic [DW-1:0]  r_edge_total;
    logic [8:0]     r_last_src;
    logic [2:0]     r_status;
    logic [8:0]     r_gsize;
    logic [8:0]     r_cnt;
    logic [8:0]     r_idx;
    logic [8:0]     r_head;
    logic [8:0]     r_tail;
    logic [8:0]     r_found;
    logic [8:0]     r_j;
    logic [VW-1:0]  r_root;
    logic [DW-1:0]  r_root_deg;
    logic [DW-1:0]  r_deg;
    logic [DW-1:0]  r_k;
    logic [EW:0]    r_base;
    logic [VW-1:0]  r_nb;
    logic [DW-1:0]  r_nb_deg;
    logic [DW+VW-1:0] r_sort_rd;
    // registered read data
    logic [DW-1:0]  r_deg_rd;
    logic [EW-1:0]  r_row_rd;
    logic [VW-1:0]  r_q_rd;
    logic [VW-1:0]  r_nbr_rd;
    logic [VW-1:0]  r_pos_rd;
    logic           r_vis_rd;

    // registered read ports of degree and mark memories
    logic [VW-1:0] w_deg_addr;
    logic          w_deg_en;
    logic [VW-1:0] w_vis_addr;
    logic          w_vis_en;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.data  = r_out;

    logic [8:0] w_cnt_sat;
    assign w_cnt_sat = (i_cmd.data.vertex_count > 9'(cmr_pkg::MaxVertices))
        ? 9'(cmr_pkg::MaxVertices) : i_cmd.data.vertex_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_idx        <= '0;
            r_edge_total <= '0;
            r_last_src   <= '0;
            r_status     <= cmr_pkg::ST_OK;
            r_gsize      <= '0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    degree_mem[r_idx[VW-1:0]] <= '0;
                    visit_mem[r_idx[VW-1:0]]  <= 1'b0;
                    if (r_idx == 9'(cmr_pkg::MaxVertices - 1)) begin
                        r_state <= (r_in.cmd == cmr_pkg::CMD_CLEAR && r_gsize == 9'h1FF)
                            ? S_OUT : S_IDLE;
                        r_gsize <= '0;
                        r_out   <= '{remap_index: '0, index_valid: 1'b0,
                                     status: cmr_pkg::ST_OK};
                    end
                    r_idx <= r_idx + 9'd1;
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_in <= i_cmd.data;
                        case (i_cmd.data.cmd)
                            cmr_pkg::CMD_APPEND: r_state <= S_APP;
                            cmr_pkg::CMD_RUN: begin
                                r_cnt   <= w_cnt_sat;
                                r_gsize <= w_cnt_sat;
                                r_idx   <= '0;
                                r_state <= S_RCLR;
                            end
                            cmr_pkg::CMD_READ: r_state <= S_READ;
                            default: begin
                                r_edge_total <= '0;
                                r_last_src   <= '0;
                                r_status     <= cmr_pkg::ST_OK;
                                r_gsize      <= 9'h1FF;
                                r_idx        <= '0;
                                r_state      <= S_SWEEP;
                            end
                        endcase
                    end
                end
                S_APP: begin
                    if (r_edge_total >= DW'(cmr_pkg::MaxEdges)) begin
                        r_status <= cmr_pkg::ST_FULL;
                    end else if (r_edge_total != '0
                                 && {1'b0, r_in.vertex} < r_last_src) begin
                        r_status <= cmr_pkg::ST_ORDER;
                    end else begin
                        if (r_edge_total == '0 || {1'b0, r_in.vertex} != r_last_src)
                            row_start[r_in.vertex] <= r_edge_total[EW-1:0];
                        nbr_mem[r_edge_total[EW-1:0]] <= r_in.neighbor;
                        r_edge_total <= r_edge_total + DW'(1);
                        degree_mem[r_in.vertex] <= r_deg_rd + DW'(1);
                        r_last_src <= {1'b0, r_in.vertex};
                    end
                    r_out.remap_index <= '0;
                    r_out.index_valid <= 1'b0;
                    r_out.status      <= (r_edge_total >= DW'(cmr_pkg::MaxEdges))
                        ? cmr_pkg::ST_FULL
                        : (r_edge_total != '0 && {1'b0, r_in.vertex} < r_last_src)
                        ? cmr_pkg::ST_ORDER : r_status;
                    r_state <= S_OUT;
                end
                S_READ: begin
                    r_pos_rd <= pos_mem[r_in.vertex];
                    r_state  <= S_READ2;
                end
                S_READ2: begin
                    if ({1'b0, r_in.vertex} < r_gsize && r_vis_rd) begin
                        r_out.remap_index <= r_pos_rd;
                        r_out.index_valid <= 1'b1;
                    end else begin
                        r_out.remap_index <= '0;
                        r_out.index_valid <= 1'b0;
                    end
                    r_out.status <= r_status;
                    r_state      <= S_OUT;
                end
                S_RCLR: begin
                    // clear marks over the whole store
                    visit_mem[r_idx[VW-1:0]] <= 1'b0;
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'(cmr_pkg::MaxVertices - 1)) begin
                        if (r_cnt == '0) begin
                            r_status <= cmr_pkg::ST_EMPTY;
                            r_out    <= '{remap_index: '0, index_valid: 1'b0,
                                          status: cmr_pkg::ST_EMPTY};
                            r_state  <= S_OUT;
                        end else if (!r_in.auto_start
                                     && {1'b0, r_in.root_vertex} < r_cnt) begin
                            r_root  <= r_in.root_vertex;
                            r_state <= S_DONE;
                        end else begin
                            r_root  <= '0;
                            r_idx   <= '0;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    // r_deg_rd holds degree of vertex r_idx
                    if (r_idx == '0 || r_deg_rd < r_root_deg) begin
                        r_root     <= r_idx[VW-1:0];
                        r_root_deg <= r_deg_rd;
                    end
                    if (r_idx + 9'd1 >= r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 9'd1;
                        r_state <= S_ROOTCMP;
                    end
                end
                S_ROOTCMP: r_state <= S_ROOT;
                S_DONE: begin
                    // seed queue with root
                    visit_mem[r_root] <= 1'b1;
                    queue_mem[0]      <= r_root;
                    r_head  <= '0;
                    r_tail  <= 9'd1;
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_head >= r_tail) begin
                        r_status <= (r_head == r_cnt) ? cmr_pkg::ST_OK
                                                      : cmr_pkg::ST_DISJOINT;
                        r_out <= '{remap_index: '0, index_valid: 1'b0,
                                   status: (r_head == r_cnt) ? cmr_pkg::ST_OK
                                                             : cmr_pkg::ST_DISJOINT};
                        r_state <= S_OUT;
                    end else begin
                        r_q_rd  <= queue_mem[r_head[VW-1:0]];
                        r_state <= S_POP2;
                    end
                end
                S_POP2: begin
                    pos_mem[r_q_rd] <= r_head[VW-1:0];
                    r_head <= r_head + 9'd1;
                    r_row_rd <= row_start[r_q_rd];
                    r_state  <= S_POP3;
                end
                S_POP3: begin
                    r_deg   <= r_deg_rd;
                    r_base  <= (r_deg_rd != '0) ? {1'b0, r_row_rd} : '0;
                    r_k     <= '0;
                    r_found <= '0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    if (r_k >= r_deg || r_base >= (EW+1)'(cmr_pkg::MaxEdges)) begin
                        r_idx   <= '0;
                        r_state <= S_COPY;
                    end else begin
                        r_nbr_rd <= nbr_mem[r_base[EW-1:0]];
                        r_state  <= S_NB2;
                    end
                end
                S_NB2: begin
                    r_nb <= r_nbr_rd;
                    r_state <= S_NB3;
                end
                S_NB3: begin
                    r_k    <= r_k + DW'(1);
                    r_base <= r_base + (EW+1)'(1);
                    if ({1'b0, r_nb} < r_cnt && !r_vis_rd) begin
                        visit_mem[r_nb] <= 1'b1;
                        r_nb_deg <= r_deg_rd;
                        r_j      <= r_found;
                        r_found  <= r_found + 9'd1;
                        r_state  <= S_SORT;
                    end else begin
                        r_state <= S_NB;
                    end
                end
                S_SORT: begin
                    if (r_j == '0) begin
                        sort_mem[0] <= {r_nb_deg, r_nb};
                        r_state <= S_NB;
                    end else begin
                        r_sort_rd <= sort_mem[VW'(r_j - 9'd1)];
                        r_state   <= S_SORT2;
                    end
                end
                S_SORT2: begin
                    // shift larger keys up, one per pass
                    if (r_sort_rd[DW+VW-1:VW] > r_nb_deg) begin
                        sort_mem[r_j[VW-1:0]] <= r_sort_rd;
                        r_j     <= r_j - 9'd1;
                        r_state <= S_SORT;
                    end else begin
                        sort_mem[r_j[VW-1:0]] <= {r_nb_deg, r_nb};
                        r_state <= S_NB;
                    end
                end
                S_COPY: begin
                    if (r_idx >= r_found
                        || r_tail >= 9'(cmr_pkg::MaxVertices)) begin
                        r_state <= S_POP;
                    end else begin
                        r_sort_rd <= sort_mem[r_idx[VW-1:0]];
                        r_state   <= S_COPY2;
                    end
                end
                S_COPY2: begin
                    queue_mem[r_tail[VW-1:0]] <= r_sort_rd[VW-1:0];
                    r_tail  <= r_tail + 9'd1;
                    r_idx   <= r_idx + 9'd1;
                    r_state <= S_COPY;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        w_deg_en   = 1'b0;
        w_deg_addr = i_cmd.data.vertex;
        w_vis_en   = 1'b0;
        w_vis_addr = i_cmd.data.vertex;
        case (r_state)
            S_IDLE: begin
                w_deg_en = 1'b1;
                w_vis_en = 1'b1;
            end
            S_RCLR: begin
                w_deg_en   = 1'b1;
                w_deg_addr = '0;
            end
            S_ROOT: begin
                w_deg_en   = 1'b1;
                w_deg_addr = VW'(r_idx + 9'd1);
            end
            S_POP2: begin
                w_deg_en   = 1'b1;
                w_deg_addr = r_q_rd;
            end
            S_NB2: begin
                w_deg_en   = 1'b1;
                w_deg_addr = r_nbr_rd;
                w_vis_en   = 1'b1;
                w_vis_addr = r_nbr_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_deg_en) r_deg_rd <= degree_mem[w_deg_addr];
        if (w_vis_en) r_vis_rd <= visit_mem[w_vis_addr];
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))
        else $error("result changed while stalled");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.ready && o_res.valid))
        else $error("ready while result pending");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> r_head <= r_tail)
        else $error("queue head passed tail");
    a_valid_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.index_valid |-> o_res.data.remap_index == '0)
        else $error("index nonzero while invalid");
endmodule

[verif/cuthill_mckee_reorder_tb.sv]
`timescale 1ns / 1ps
module cuthill_mckee_reorder_tb;
    localparam int CycleLimit = 3000000;

    // Mirrors the graph store and the last ordering; predicts one result per command.
    class cm_scoreboard;
        int unsigned degree[cmr_pkg::MaxVertices];
        int unsigned row_first[cmr_pkg::MaxVertices];
        int unsigned adj[cmr_pkg::MaxEdges];
        int unsigned edge_cnt;
        int unsigned last_src;
        bit          reached[cmr_pkg::MaxVertices];
        int unsigned new_pos[cmr_pkg::MaxVertices];
        logic [2:0]  run_st;
        int unsigned order_size;
        cmr_pkg::t_out pending_q[$];
        int          errors;

        function new();
            foreach (degree[i]) degree[i] = 0;
            foreach (reached[i]) reached[i] = 0;
            edge_cnt = 0;
            last_src = 0;
            run_st = cmr_pkg::ST_OK;
            order_size = 0;
            errors = 0;
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        function void append_edge(int unsigned src, int unsigned dst);
            if (edge_cnt >= cmr_pkg::MaxEdges) begin
                run_st = cmr_pkg::ST_FULL;
                return;
            end
            if (edge_cnt > 0 && src < last_src) begin
                run_st = cmr_pkg::ST_ORDER;
                return;
            end
            if (edge_cnt == 0 || src != last_src) row_first[src] = edge_cnt;
            adj[edge_cnt] = dst;
            edge_cnt++;
            degree[src]++;
            last_src = src;
        endfunction

        function void order_graph(int unsigned count, int unsigned root, bit automatic_root);
            int unsigned fifo[cmr_pkg::MaxVertices];
            int unsigned head, tail, cur, base, nb, j;
            int unsigned found[$];
            head = 0;
            tail = 0;
            if (count > cmr_pkg::MaxVertices) count = cmr_pkg::MaxVertices;
            order_size = count;
            foreach (reached[i]) reached[i] = 0;
            if (count == 0) begin
                run_st = cmr_pkg::ST_EMPTY;
                return;
            end
            if (automatic_root || root >= count) begin
                root = 0;
                for (int unsigned v = 1; v < count; v++)
                    if (degree[v] < degree[root]) root = v;
            end
            reached[root] = 1;
            fifo[tail++] = root;
            while (head < tail) begin
                cur = fifo[head];
                new_pos[cur] = head;
                head++;
                base = degree[cur] ? row_first[cur] : 0;
                found.delete();
                for (int unsigned k = 0; k < degree[cur] && base + k < cmr_pkg::MaxEdges;
                     k++) begin
                    nb = adj[base + k];
                    if (nb < count && !reached[nb]) begin
                        reached[nb] = 1;
                        // stable insert by degree
                        j = found.size();
                        while (j > 0 && degree[found[j - 1]] > degree[nb]) j--;
                        found.insert(j, nb);
                    end
                end
                foreach (found[k])
                    if (tail < cmr_pkg::MaxVertices) fifo[tail++] = found[k];
            end
            run_st = (head == count) ? cmr_pkg::ST_OK : cmr_pkg::ST_DISJOINT;
        endfunction

        function void note(cmr_pkg::t_in it);
            cmr_pkg::t_out r;
            r = '0;
            case (it.cmd)
                cmr_pkg::CMD_APPEND: append_edge(32'(it.vertex), 32'(it.neighbor));
                cmr_pkg::CMD_RUN:
                    order_graph(32'(it.vertex_count), 32'(it.root_vertex), it.auto_start);
                cmr_pkg::CMD_READ: begin
                    if (32'(it.vertex) < order_size && reached[it.vertex]) begin
                        r.remap_index = 8'(new_pos[it.vertex]);
                        r.index_valid = 1'b1;
                    end
                end
                default: begin
                    foreach (degree[i]) degree[i] = 0;
                    foreach (reached[i]) reached[i] = 0;
                    edge_cnt = 0;
                    last_src = 0;
                    run_st = cmr_pkg::ST_OK;
                    order_size = 0;
                end
            endcase
            r.status = run_st;
            pending_q.insert(pending_q.size(), r);
        endfunction

        task check(cmr_pkg::t_out got);
            cmr_pkg::t_out want;
            if (pending_q.size() == 0) begin
                report("unexpected result item", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.remap_index !== want.remap_index)
                report("remap_index", got.remap_index, want.remap_index);
            if (got.index_valid !== want.index_valid)
                report("index_valid", got.index_valid, want.index_valid);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    cmr_in_if  cmd_ch();
    cmr_out_if res_ch();

    cuthill_mckee_reorder i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    cm_scoreboard sb = new();
    int unsigned  idle_pct;
    int unsigned  stall_pct;
    int unsigned  cycles;
    int unsigned  sent;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check(res_ch.data);
    end

    task automatic send(logic [1:0] c, int unsigned vtx, int unsigned nb,
                        int unsigned cnt, int unsigned root, int unsigned auto_root);
        cmr_pkg::t_in it;
        it.cmd = c;
        it.vertex = 8'(vtx);
        it.neighbor = 8'(nb);
        it.vertex_count = 9'(cnt);
        it.root_vertex = 8'(root);
        it.auto_start = 1'(auto_root);
        if ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note(it);
        sent++;
    endtask

    task drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // clear, load a random, mostly symmetric graph, order it, read positions back
    task automatic graph_session();
        int unsigned n, ecnt, cnt, far_src;
        int unsigned nbrs[cmr_pkg::MaxVertices][$];
        n = ($urandom_range(19) == 0) ? $urandom_range(17, 256) : $urandom_range(1, 16);
        ecnt = $urandom_range(0, (n < 24) ? 2 * n : 40);
        for (int i = 0; i < ecnt; i++) begin
            int unsigned a, b;
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            nbrs[a].insert(nbrs[a].size(), b);
            if (a != b) nbrs[b].insert(nbrs[b].size(), a);
        end
        // a far endpoint now and then
        if ($urandom_range(3) == 0) begin
            far_src = $urandom_range(n - 1);
            nbrs[far_src].insert(nbrs[far_src].size(), $urandom_range(255));
        end
        send(cmr_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int unsigned s = 0; s < n; s++)
            foreach (nbrs[s][k])
                send(cmr_pkg::CMD_APPEND, s, nbrs[s][k], $urandom, $urandom, $urandom);
        cnt = ($urandom_range(4) == 0) ? $urandom_range(0, 511) : n;
        send(cmr_pkg::CMD_RUN, $urandom, $urandom, cnt, $urandom_range(n + 2),
             $urandom_range(1));
        repeat ($urandom_range(2, 10))
            send(cmr_pkg::CMD_READ, $urandom_range(n + 2), $urandom, $urandom, $urandom,
                 $urandom);
    endtask

    task noise_item();
        send(2'($urandom_range(2)), $urandom, $urandom, $urandom_range(0, 511), $urandom,
             $urandom);
    endtask

    task random_phase(int unsigned budget);
        int unsigned goal;
        goal = sent + budget;
        while (sent < goal) begin
            if ($urandom_range(99) < 85) graph_session();
            else noise_item();
        end
        drain();
    endtask

    initial begin
        cycles = 0;
        sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send(cmr_pkg::CMD_RUN, 0, 0, 0, 0, 0);
        send(cmr_pkg::CMD_READ, 0, 0, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 3, 5, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 3, 1, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 2, 4, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 4, 3, 0, 0, 0);
        send(cmr_pkg::CMD_CLEAR, 255, 255, 511, 255, 1);
        send(cmr_pkg::CMD_APPEND, 0, 1, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 1, 2, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 1, 0, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 1, 200, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 2, 1, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 2, 3, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 3, 2, 0, 0, 0);
        send(cmr_pkg::CMD_APPEND, 255, 0, 0, 0, 0);
        send(cmr_pkg::CMD_RUN, 0, 0, 6, 2, 0);
        for (int v = 0; v < 6; v++) send(cmr_pkg::CMD_READ, v, 0, 0, 0, 0);
        send(cmr_pkg::CMD_RUN, 0, 0, 4, 250, 0);
        send(cmr_pkg::CMD_READ, 3, 0, 0, 0, 0);
        send(cmr_pkg::CMD_RUN, 0, 0, 300, 0, 1);
        send(cmr_pkg::CMD_READ, 255, 0, 0, 0, 0);
        drain();

        random_phase(120);
        idle_pct = 81;
        random_phase(120);
        idle_pct = 0;
        stall_pct = 81;
        random_phase(120);
        idle_pct = 38;
        stall_pct = 38;
        random_phase(120);
        stall_pct = 0;
        drain();
        repeat (300) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[cuthill_mckee_reorder.f]
hw/rtl/cmr_pkg.sv
hw/rtl/cmr_if.sv
hw/rtl/cuthill_mckee_reorder.sv
verif/cuthill_mckee_reorder_tb.sv
